### hw/rtl/ucrb_pkg.sv
// Shared types and constants for the UART receive/transmit ring buffer core.
// Used by ucrb_ring and uart_rx_tx_ring_buffers_core; no dependencies.
package ucrb_pkg;

    localparam int RX_DEPTH_DEF = 64;
    localparam int TX_DEPTH_DEF = 64;
    localparam int COUNT_W      = 6;

    typedef logic [7:0]         byte_t;
    typedef logic [COUNT_W-1:0] count_t;

    typedef enum logic [2:0] {
        CMD_RX_BYTE    = 3'd0,
        CMD_LINE_READY = 3'd1,
        CMD_READ       = 3'd2,
        CMD_PEEK       = 3'd3,
        CMD_WRITE      = 3'd4,
        CMD_CLEAR_RX   = 3'd5
    } cmd_t;

    // Operation request to one ring
    typedef struct packed {
        logic push;
        logic pop;
        logic rd;
        logic clear;
    } ring_op_t;

    // Status of one ring, taken from its current pointers
    typedef struct packed {
        logic   empty;
        logic   full;
        count_t used;
        count_t space;
    } ring_stat_t;

endpackage

### hw/rtl/ucrb_ring.sv
// One byte ring: synchronous memory with registered read data and its pointers.
// Depends on ucrb_pkg.
module ucrb_ring #(
    parameter int DEPTH = ucrb_pkg::RX_DEPTH_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  ucrb_pkg::ring_op_t   op,
    input  ucrb_pkg::byte_t      wdata,
    output ucrb_pkg::byte_t      rdata,
    output ucrb_pkg::ring_stat_t stat
);

    localparam int AW = $clog2(DEPTH);

    ucrb_pkg::byte_t mem [DEPTH];
    ucrb_pkg::byte_t rdata_reg;

    logic [AW-1:0] wptr_reg, wptr_next;
    logic [AW-1:0] rptr_reg, rptr_next;
    logic [AW-1:0] wptr_inc, rptr_inc;
    logic [AW-1:0] used;

    assign wptr_inc = (wptr_reg == AW'(DEPTH - 1)) ? '0 : wptr_reg + AW'(1);
    assign rptr_inc = (rptr_reg == AW'(DEPTH - 1)) ? '0 : rptr_reg + AW'(1);

    // Add the depth back when the write pointer has wrapped behind the read pointer
    assign used = (wptr_reg >= rptr_reg) ? (wptr_reg - rptr_reg)
                                         : (wptr_reg - rptr_reg + AW'(DEPTH));

    assign stat.empty = (wptr_reg == rptr_reg);
    assign stat.full  = (wptr_inc == rptr_reg);
    assign stat.used  = ucrb_pkg::count_t'(used);
    assign stat.space = ucrb_pkg::count_t'(AW'(DEPTH - 1) - used);

    always_comb
    begin
        wptr_next = wptr_reg;
        rptr_next = rptr_reg;
        if (op.push)
        begin
            wptr_next = wptr_inc;
        end
        if (op.pop)
        begin
            rptr_next = rptr_inc;
        end
        if (op.clear)
        begin
            rptr_next = wptr_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg <= '0;
            rptr_reg <= '0;
        end
        else
        begin
            wptr_reg <= wptr_next;
            rptr_reg <= rptr_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (op.push)
        begin
            mem[wptr_reg] <= wdata;
        end
        if (op.rd)
        begin
            rdata_reg <= mem[rptr_reg];
        end
    end

    assign rdata = rdata_reg;

endmodule

### hw/rtl/uart_rx_tx_ring_buffers_core.sv
// Top level of the UART ring buffer core: command decode, result register, rings.
// Depends on ucrb_pkg and ucrb_ring.
// A result is registered and appears in the cycle after its command word is accepted.
// Throughput: one command per cycle while results are taken; each command makes
// at most one access to each ring memory; the result register frees as its word is taken.
// Reset: all ring pointers clear, both rings empty, no result pending.
module uart_rx_tx_ring_buffers_core #(
    parameter int RX_DEPTH = ucrb_pkg::RX_DEPTH_DEF,
    parameter int TX_DEPTH = ucrb_pkg::TX_DEPTH_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,  // data[7:0], line_ready[8], zero pad
    input  logic [3:0]  s_axis_tuser,  // cmd[2:0], parity_error[3]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata   // rx_byte[7:0], rx_got[8], line_byte[16:9],
                                       // line_send[17], write_taken[18],
                                       // rx_dropped[19], rx_count[25:20], tx_free[31:26]
);

    ucrb_pkg::cmd_t       cmd;
    ucrb_pkg::byte_t      data;
    logic                 parity_error;
    logic                 line_ready;
    logic                 in_fire;

    ucrb_pkg::ring_op_t   rx_op, tx_op;
    ucrb_pkg::ring_stat_t rx_stat, tx_stat;
    ucrb_pkg::byte_t      rx_rdata, tx_rdata;

    logic out_valid_reg, out_valid_next;
    logic rx_got_reg, rx_got_next;
    logic line_send_reg, line_send_next;
    logic line_mem_reg, line_mem_next;
    logic taken_reg, taken_next;
    logic dropped_reg, dropped_next;
    ucrb_pkg::byte_t line_data_reg, line_data_next;

    ucrb_pkg::byte_t rx_byte;
    ucrb_pkg::byte_t line_byte;

    assign cmd          = ucrb_pkg::cmd_t'(s_axis_tuser[2:0]);
    assign parity_error = s_axis_tuser[3];
    assign data         = s_axis_tdata[7:0];
    assign line_ready   = s_axis_tdata[8];

    assign s_axis_tready = !out_valid_reg || m_axis_tready;
    assign in_fire       = s_axis_tvalid && s_axis_tready;

    always_comb
    begin
        rx_op          = '0;
        tx_op          = '0;
        rx_got_next    = 1'b0;
        line_send_next = 1'b0;
        line_mem_next  = 1'b0;
        taken_next     = 1'b0;
        dropped_next   = 1'b0;
        line_data_next = data;
        if (in_fire)
        begin
            case (cmd)
                ucrb_pkg::CMD_RX_BYTE:
                begin
                    if (parity_error || rx_stat.full)
                    begin
                        dropped_next = 1'b1;
                    end
                    else
                    begin
                        rx_op.push = 1'b1;
                    end
                end
                ucrb_pkg::CMD_LINE_READY:
                begin
                    if (!tx_stat.empty)
                    begin
                        tx_op.rd       = 1'b1;
                        tx_op.pop      = 1'b1;
                        line_send_next = 1'b1;
                        line_mem_next  = 1'b1;
                    end
                end
                ucrb_pkg::CMD_READ, ucrb_pkg::CMD_PEEK:
                begin
                    if (!rx_stat.empty)
                    begin
                        rx_op.rd    = 1'b1;
                        rx_op.pop   = (cmd == ucrb_pkg::CMD_READ);
                        rx_got_next = 1'b1;
                    end
                end
                ucrb_pkg::CMD_WRITE:
                begin
                    // Bypass the ring when nothing is queued and the line is free
                    if (tx_stat.empty && line_ready)
                    begin
                        line_send_next = 1'b1;
                        taken_next     = 1'b1;
                    end
                    else if (!tx_stat.full)
                    begin
                        tx_op.push = 1'b1;
                        taken_next = 1'b1;
                    end
                end
                ucrb_pkg::CMD_CLEAR_RX:
                begin
                    rx_op.clear = 1'b1;
                end
                default:
                begin
                end
            endcase
        end
    end

    assign out_valid_next = in_fire || (out_valid_reg && !m_axis_tready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    // Result flags load on accept and hold while the word waits
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            rx_got_reg    <= rx_got_next;
            line_send_reg <= line_send_next;
            line_mem_reg  <= line_mem_next;
            taken_reg     <= taken_next;
            dropped_reg   <= dropped_next;
            line_data_reg <= line_data_next;
        end
    end

    ucrb_ring #(
        .DEPTH (RX_DEPTH)
    ) u_rx_ring (
        .clk   (clk),
        .rst_n (rst_n),
        .op    (rx_op),
        .wdata (data),
        .rdata (rx_rdata),
        .stat  (rx_stat)
    );

    ucrb_ring #(
        .DEPTH (TX_DEPTH)
    ) u_tx_ring (
        .clk   (clk),
        .rst_n (rst_n),
        .op    (tx_op),
        .wdata (data),
        .rdata (tx_rdata),
        .stat  (tx_stat)
    );

    assign rx_byte   = rx_got_reg ? rx_rdata : '0;
    assign line_byte = !line_send_reg ? '0 : (line_mem_reg ? tx_rdata : line_data_reg);

    // Pointers only move on accept, so the counts match the pending word
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {tx_stat.space, rx_stat.used, dropped_reg, taken_reg,
                            line_send_reg, line_byte, rx_got_reg, rx_byte};

    assert property (@(posedge clk) disable iff (!rst_n)
        !(rx_op.push && rx_stat.full) && !(tx_op.push && tx_stat.full))
        else $error("push into a full ring");

    assert property (@(posedge clk) disable iff (!rst_n)
        rx_op.clear |=> rx_stat.empty)
        else $error("receive ring not empty after clear");

    assert property (@(posedge clk) disable iff (!rst_n)
        (in_fire && (cmd == ucrb_pkg::CMD_READ) && !rx_stat.empty)
        |=> (rx_stat.used == $past(rx_stat.used) - ucrb_pkg::count_t'(1)))
        else $error("read did not remove one byte");

    assert property (@(posedge clk) disable iff (!rst_n)
        (in_fire && (cmd == ucrb_pkg::CMD_WRITE) && !tx_stat.empty)
        |-> !line_send_next)
        else $error("write bypassed a non-empty transmit ring");

endmodule
